[sv/sti_pkg.sv]
// package for the sorted table: sizes, payload structs, status codes
// and the cell control struct; no dependencies
`default_nettype none

package sti_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_DELETED   = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef logic signed [VALUE_BITS-1:0] entry_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

  // sign-extend or wrap the 32-bit input to the stored width
  function automatic entry_t fit_value(logic signed [31:0] x);
    return VALUE_BITS'(x);
  endfunction

endpackage

`default_nettype wire

[sv/sti_cell.sv]
// one slot of the sorted table: holds an entry, compares it with the
// broadcast value and shifts with its neighbors; uses sti_pkg
`default_nettype none

module sti_cell
  import sti_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     value,
  input  wire logic       occupied,
  input  wire entry_t     left_entry,
  input  wire logic       left_less,
  input  wire entry_t     right_entry,
  output entry_t          entry,
  output logic            less,
  output logic            eq
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   less_r;
  logic   eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      less_r <= occupied && (entry_r < value);
      eq_r   <= occupied && (entry_r == value);
    end
    entry_r <= entry_nxt;
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en && !less_r) begin
      // first cell not below the value takes it, the rest move right
      entry_nxt = left_less ? value : left_entry;
    end else if (ctrl.del_en && !less_r) begin
      entry_nxt = right_entry;
    end
  end

  assign entry = entry_r;
  assign less  = less_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

[sv/sorted_table_insert_delete.sv]
// Sorted table with insert and delete, built as a row of sti_cell slots.
// Each item is registered on transfer, compared in every cell in S_CMP (a registered
// compare), then shifted in S_APPLY. The input stalls until the item is applied, so a
// new item is taken only after the last one; a waiting result holds the apply, not the compare.
// Reset (rst_n low, synchronous) empties the table and drops any pending result.
// Uses sti_pkg and sti_cell.
`default_nettype none

module sorted_table_insert_delete
  import sti_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             cmd_r;
  entry_t           val_r;

  entry_t             cell_entry [CAPACITY];
  logic [CAPACITY-1:0] less_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] occ_vec;
  cell_ctrl_t          ctrl;

  logic             in_xfer;
  logic             apply_go;
  logic             found;
  logic             full;
  logic [CNT_W+4:0] cnt_ext;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || !out_stall);
  assign found    = |eq_vec;
  assign full     = (count_r == CNT_W'(CAPACITY));

  assign ctrl = '{
    cmp_en: (state_r == S_CMP),
    ins_en: apply_go && (cmd_r == CMD_INSERT) && !full,
    del_en: apply_go && (cmd_r == CMD_DELETE) && found
  };

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_l;

      assign occ_vec[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_first
        // nothing sits left of the first cell, so it takes the value whenever it shifts on an insert
        assign left_e = val_r;
        assign left_l = 1'b1;
      end else begin : g_mid
        assign left_e = cell_entry[gi-1];
        assign left_l = less_vec[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_e = cell_entry[gi];
      end else begin : g_inner
        assign right_e = cell_entry[gi+1];
      end

      sti_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .value       (val_r),
        .occupied    (occ_vec[gi]),
        .left_entry  (left_e),
        .left_less   (left_l),
        .right_entry (right_e),
        .entry       (cell_entry[gi]),
        .less        (less_vec[gi]),
        .eq          (eq_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt_ext       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) begin
          if (cmd_r == CMD_INSERT) begin
            if (full) begin
              out_data_nxt.status = STATUS_FULL;
            end else begin
              out_data_nxt.status = STATUS_INSERTED;
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            if (found) begin
              out_data_nxt.status = STATUS_DELETED;
              count_nxt = count_r - CNT_W'(1);
            end else begin
              out_data_nxt.status = STATUS_NOT_FOUND;
            end
          end
          cnt_ext            = {5'b0, count_nxt};
          out_data_nxt.count = cnt_ext[4:0];
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_xfer) begin
      cmd_r <= in_data.command;
      val_r <= fit_value(in_data.value);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
